// File: hdl/jce_pkg.sv
// Shared constants, types and codes for the JPEG coefficient expander.
package jce_pkg;

  localparam int BLOCK_COEFFS   = 64;
  localparam int NUM_COMPONENTS = 3;

  localparam int COEF_W = 16;
  localparam int POS_W  = $clog2(BLOCK_COEFFS) + 1;
  localparam int COMP_W = 2;
  localparam int SYM_W  = 8;
  localparam int MAG_W  = 15;
  localparam int RUN_W  = 4;

  localparam logic [SYM_W-1:0] SYM_EOB = 8'h00;
  localparam logic [POS_W-1:0] POS_CLOSED = POS_W'(BLOCK_COEFFS);
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(BLOCK_COEFFS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DC,
    S_RUN,
    S_VAL,
    S_FILL
  } jce_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic emit_dc;
    logic emit_zero;
    logic emit_val;
  } jce_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic in_starts;
    logic in_eob;
    logic block_open;
    logic run_zero;
    logic at_last;
    logic out_free;
  } jce_sts_t;

endpackage

// File: hdl/jce_ctrl.sv
// Sequencing state machine of the JPEG coefficient expander.
module jce_ctrl
  import jce_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  jce_sts_t   sts,
  output jce_cmd_t   cmd,
  output logic       in_stall
);

  jce_state_t state_r;
  jce_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (sts.in_starts) begin
            state_nxt = S_DC;
          end else if (!sts.block_open) begin
            state_nxt = S_IDLE;
          end else if (sts.in_eob) begin
            state_nxt = S_FILL;
          end else begin
            state_nxt = S_RUN;
          end
        end
      end
      S_DC: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      S_RUN: begin
        if (sts.run_zero || !sts.block_open) state_nxt = S_VAL;
      end
      S_VAL: begin
        if (!sts.block_open || sts.out_free) state_nxt = S_IDLE;
      end
      S_FILL: begin
        if (sts.out_free && sts.at_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: cmd.accept   = in_valid;
      S_DC:   cmd.emit_dc  = sts.out_free;
      S_RUN:  cmd.emit_zero = sts.out_free && !sts.run_zero && sts.block_open;
      S_VAL:  cmd.emit_val = sts.out_free && sts.block_open;
      S_FILL: cmd.emit_zero = sts.out_free;
      default: cmd = '0;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// File: hdl/jce_dp.sv
// Datapath of the JPEG coefficient expander: item registers, predictors, output register.
module jce_dp
  import jce_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  jce_cmd_t                 cmd,
  output jce_sts_t                 sts,
  input  logic                     in_starts_block,
  input  logic [COMP_W-1:0]        in_component,
  input  logic [SYM_W-1:0]         in_symbol,
  input  logic [MAG_W-1:0]         in_magnitude_bits,
  input  logic                     in_clear_predictors,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [COEF_W-1:0] out_coefficient,
  output logic [POS_W-2:0]         out_position,
  output logic [COMP_W-1:0]        out_component,
  output logic                     out_block_last
);

  // JPEG sign extension of the low size bits.
  function automatic logic [COEF_W-1:0] extend_bits(input logic [3:0] size,
                                                     input logic [MAG_W-1:0] bits);
    logic [MAG_W-1:0] mask;
    logic [MAG_W-1:0] v;
    logic [COEF_W-1:0] half;
    logic [COEF_W-1:0] res;
    mask = MAG_W'((16'd1 << size) - 16'd1);
    v    = bits & mask;
    half = (16'd1 << size) >> 1;
    if (size == 4'd0) begin
      res = '0;
    end else if ({1'b0, v} < half) begin
      res = {1'b0, v} + 16'd1 - (16'd1 << size);
    end else begin
      res = {1'b0, v};
    end
    return res;
  endfunction

  logic [COEF_W-1:0] pred_r [NUM_COMPONENTS];
  logic [COEF_W-1:0] ext_r;
  logic [RUN_W-1:0]  run_r;
  logic [COMP_W-1:0] comp_r;
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  pos_nxt;
  logic [COMP_W-1:0] open_comp_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [COEF_W-1:0] out_coef_r;
  logic [POS_W-2:0]  out_pos_r;
  logic [COMP_W-1:0] out_comp_r;
  logic              out_last_r;
  logic [COEF_W-1:0] pred_sel;
  logic              comp_has_pred;
  logic [COEF_W-1:0] dc_sum;
  logic              load;

  always_comb begin
    pred_sel      = '0;
    comp_has_pred = 1'b0;
    for (int i = 0; i < NUM_COMPONENTS; i++) begin
      if (comp_r == COMP_W'(i)) begin
        pred_sel      = pred_r[i];
        comp_has_pred = 1'b1;
      end
    end
  end

  assign dc_sum = pred_sel + ext_r;
  assign load   = cmd.emit_dc || cmd.emit_zero || cmd.emit_val;

  always_comb begin
    pos_nxt = pos_r;
    if (cmd.emit_dc) begin
      pos_nxt = POS_W'(1);
    end else if (cmd.emit_zero || cmd.emit_val) begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_CLOSED;
      open_comp_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_COMPONENTS; i++) pred_r[i] <= '0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.accept && in_clear_predictors) begin
        for (int i = 0; i < NUM_COMPONENTS; i++) pred_r[i] <= '0;
      end
      if (cmd.emit_dc) begin
        open_comp_r <= comp_r;
        for (int i = 0; i < NUM_COMPONENTS; i++) begin
          if (comp_r == COMP_W'(i)) pred_r[i] <= dc_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ext_r  <= extend_bits(in_symbol[3:0], in_magnitude_bits);
      run_r  <= in_symbol[7:4];
      comp_r <= in_component;
    end else if (cmd.emit_zero && run_r != '0) begin
      run_r <= run_r - RUN_W'(1);
    end
    if (load) begin
      if (cmd.emit_dc) begin
        out_coef_r <= comp_has_pred ? dc_sum : ext_r;
        out_pos_r  <= '0;
        out_comp_r <= comp_r;
        out_last_r <= 1'b0;
      end else begin
        out_coef_r <= cmd.emit_val ? ext_r : '0;
        out_pos_r  <= pos_r[POS_W-2:0];
        out_comp_r <= open_comp_r;
        out_last_r <= (pos_r == POS_LAST);
      end
    end
  end

  assign sts.in_starts  = in_starts_block;
  assign sts.in_eob     = (in_symbol == SYM_EOB);
  assign sts.block_open = (pos_r < POS_CLOSED);
  assign sts.run_zero   = (run_r == '0);
  assign sts.at_last    = (pos_r == POS_LAST);
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_coefficient = out_coef_r;
  assign out_position    = out_pos_r;
  assign out_component   = out_comp_r;
  assign out_block_last  = out_last_r;

endmodule

// File: hdl/jpeg_coefficient_expander_unit.sv
// Top level of the JPEG baseline coefficient expander.
//
// The input channel takes one Huffman-decoded symbol per transaction together
// with its appended magnitude bits. A DC transaction opens a block and adds
// the sign-extended category bits to the component's predictor; AC
// transactions emit their zero run and then their value; end of block
// zero-fills the block. Each result transaction carries one coefficient with
// its zigzag position, its component and a flag on position 63.
// One symbol is processed at a time. Results leave at up to one per cycle,
// unless the receiver stalls, through a single output register. A DC symbol
// passes the DC state, an AC symbol the run state for its zeros and then the
// value state, end of block the fill state; an AC symbol with no block open
// is consumed while idle. The first result is loaded in the DC, run or fill
// state, or in the value state for an AC symbol with no zero run.
// The output register is the only buffer: while the receiver stalls, the
// pending coefficient holds and the sequencer waits, so input stall rises.
// Synchronous reset zeroes the predictors, closes any open block and drops
// a pending result.
module jpeg_coefficient_expander_unit
  import jce_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_starts_block,
  input  logic [COMP_W-1:0]        in_component,
  input  logic [SYM_W-1:0]         in_symbol,
  input  logic [MAG_W-1:0]         in_magnitude_bits,
  input  logic                     in_clear_predictors,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [COEF_W-1:0] out_coefficient,
  output logic [POS_W-2:0]         out_position,
  output logic [COMP_W-1:0]        out_component,
  output logic                     out_block_last
);

  // Commands from the sequencer and status back from the datapath.
  jce_cmd_t cmd;
  jce_sts_t sts;

  // The sequencer accepts a transaction only while idle and then walks the zero
  // run, the value or the fill one coefficient per cycle while not stalled.
  jce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // The datapath holds the captured symbol, the predictors, the block
  // position and the output register.
  jce_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_starts_block     (in_starts_block),
    .in_component        (in_component),
    .in_symbol           (in_symbol),
    .in_magnitude_bits   (in_magnitude_bits),
    .in_clear_predictors (in_clear_predictors),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_coefficient     (out_coefficient),
    .out_position        (out_position),
    .out_component       (out_component),
    .out_block_last      (out_block_last)
  );

endmodule

// File: test/jpeg_coefficient_expander_unit_tb.sv
// Self-checking testbench for the JPEG baseline coefficient expander.
`timescale 1ns / 1ps

module jpeg_coefficient_expander_unit_tb
  import jce_pkg::*;
();

  // The run length of a zero-run-length symbol (sixteen zeros) is used by name.
  localparam logic [SYM_W-1:0] SYM_ZRL = 8'hF0;

  localparam int TOTAL_SYMBOLS = 450;
  localparam int IDLE_PERCENT  = 9;
  localparam int STALL_LIMIT   = 2000;
  localparam int TAIL_CYCLES   = 20;

  // The receiver holds off once, after this many coefficients, for this long.
  localparam int HOLD_AT       = 400;
  localparam int HOLD_CYCLES   = 300;

  // One symbol transaction on the input channel.
  typedef struct packed {
    logic               starts;
    logic [COMP_W-1:0]  comp;
    logic [SYM_W-1:0]   sym;
    logic [MAG_W-1:0]   mag;
    logic               clr;
  } symbol_item_t;

  // One coefficient transaction on the result channel.
  typedef struct packed {
    logic signed [COEF_W-1:0] value;
    logic [POS_W-2:0]         pos;
    logic [COMP_W-1:0]        comp;
    logic                     is_last;
  } coef_item_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_starts_block = 1'b0;
  logic [COMP_W-1:0]        in_component = '0;
  logic [SYM_W-1:0]         in_symbol = '0;
  logic [MAG_W-1:0]         in_magnitude_bits = '0;
  logic                     in_clear_predictors = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [COEF_W-1:0] out_coefficient;
  logic [POS_W-2:0]         out_position;
  logic [COMP_W-1:0]        out_component;
  logic                     out_block_last;

  jpeg_coefficient_expander_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_starts_block     (in_starts_block),
    .in_component        (in_component),
    .in_symbol           (in_symbol),
    .in_magnitude_bits   (in_magnitude_bits),
    .in_clear_predictors (in_clear_predictors),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_coefficient     (out_coefficient),
    .out_position        (out_position),
    .out_component       (out_component),
    .out_block_last      (out_block_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Symbols waiting to be offered, and coefficients the decoder must still produce.
  symbol_item_t symbol_queue[$];
  coef_item_t   expected_coefs[$];

  // Our own copy of the decoder state: DC predictors, the next zigzag index
  // (BLOCK_COEFFS when no block is open) and the component of the open block.
  logic [COEF_W-1:0] dc_pred [NUM_COMPONENTS];
  int                next_pos = BLOCK_COEFFS;
  logic [COMP_W-1:0] open_comp = '0;

  int mismatches = 0;

  initial begin
    foreach (dc_pred[i]) dc_pred[i] = '0;
  end

  // JPEG magnitude extension: the low 'size' bits are the value when their top
  // bit is set, otherwise the value is negative (bits + 1 - 2^size).
  function automatic logic [COEF_W-1:0] magnitude_value(input logic [3:0] size,
                                                        input logic [MAG_W-1:0] bits);
    int v;
    if (size == 0) return '0;
    v = int'(bits) & ((1 << size) - 1);
    if (v < (1 << (size - 1))) v = v + 1 - (1 << size);
    return COEF_W'(v);
  endfunction

  // Records one coefficient at the next zigzag index of the open block.
  function automatic void push_coef(input logic [COEF_W-1:0] value);
    coef_item_t c;
    c.value   = value;
    c.pos     = (POS_W-1)'(next_pos);
    c.comp    = open_comp;
    c.is_last = (next_pos == BLOCK_COEFFS - 1);
    expected_coefs.push_back(c);
    next_pos++;
  endfunction

  // Works out every coefficient that one accepted symbol produces.
  task automatic expand_symbol(input symbol_item_t s);
    logic [COEF_W-1:0] pred;
    logic [COEF_W-1:0] value;
    int                run;
    // A predictor clear always takes effect before the symbol itself.
    if (s.clr) foreach (dc_pred[i]) dc_pred[i] = '0;
    if (s.starts) begin
      // A component with no predictor decodes against zero and stores nothing.
      pred = (s.comp < NUM_COMPONENTS) ? dc_pred[s.comp] : '0;
      value = pred + magnitude_value(s.sym[3:0], s.mag);
      if (s.comp < NUM_COMPONENTS) dc_pred[s.comp] = value;
      // Any unfinished block is simply abandoned.
      open_comp = s.comp;
      next_pos = 0;
      push_coef(value);
    end else if (next_pos < BLOCK_COEFFS) begin
      if (s.sym == SYM_EOB) begin
        while (next_pos < BLOCK_COEFFS) push_coef('0);
      end else begin
        run = s.sym[7:4];
        value = magnitude_value(s.sym[3:0], s.mag);
        // Anything that would run past the end of the block is dropped.
        for (int i = 0; i < run && next_pos < BLOCK_COEFFS; i++) push_coef('0);
        if (next_pos < BLOCK_COEFFS) push_coef(value);
      end
    end
    // AC symbols with no block open produce nothing.
  endtask

  task automatic queue_symbol(input logic starts, input int comp, input int sym,
                              input int mag, input logic clr);
    symbol_item_t s;
    s.starts = starts;
    s.comp   = COMP_W'(comp);
    s.sym    = SYM_W'(sym);
    s.mag    = MAG_W'(mag);
    s.clr    = clr;
    symbol_queue.push_back(s);
  endtask

  // Driver. A new symbol is offered only when the previous transaction has
  // completed, so a stalled payload never changes and valid never looks at
  // stall. Prediction happens at the edge where the transaction is accepted.
  symbol_item_t offered;
  int           symbols_taken = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expand_symbol(offered);
        symbols_taken++;
      end
      if (!in_valid || !in_stall) begin
        // The sender never idles while symbols 250 to 329 go through.
        if (symbol_queue.size() > 0 &&
            ((symbols_taken >= 250 && symbols_taken < 330) ||
             $urandom_range(0, 99) >= IDLE_PERCENT)) begin
          offered = symbol_queue.pop_front();
          in_starts_block     <= offered.starts;
          in_component        <= offered.comp;
          in_symbol           <= offered.sym;
          in_magnitude_bits   <= offered.mag;
          in_clear_predictors <= offered.clr;
          in_valid            <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every accepted coefficient is checked against the oldest
  // expectation. The same process decides the receiver stall: random stalls,
  // a calm stretch without any, and one long hold-off that fills the decoder's
  // output register and pushes stall back onto the input channel.
  coef_item_t want;
  int         coefs_seen = 0;
  int         hold_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_coefs.size() == 0) begin
          $error("coefficient %0d at position %0d arrived with nothing expected",
                 out_coefficient, out_position);
          mismatches++;
        end else begin
          want = expected_coefs.pop_front();
          if (out_coefficient !== want.value) begin
            $error("coefficient: expected %0d, got %0d", want.value, out_coefficient);
            mismatches++;
          end
          if (out_position !== want.pos) begin
            $error("position: expected %0d, got %0d", want.pos, out_position);
            mismatches++;
          end
          if (out_component !== want.comp) begin
            $error("out_component: expected %0d, got %0d", want.comp, out_component);
            mismatches++;
          end
          if (out_block_last !== want.is_last) begin
            $error("block_last: expected %0d, got %0d", want.is_last, out_block_last);
            mismatches++;
          end
        end
        coefs_seen++;
        if (coefs_seen == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (coefs_seen >= 1000 && coefs_seen < 1700) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
      end
    end
  end

  // Watchdog: ends the run when neither channel completes a transaction
  // for too long.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int r;
    int pos;
    int run;
    int size;
    int comp;
    int sym;

    // Directed part. No block is open after reset, so an AC symbol is ignored.
    queue_symbol(1'b0, 0, 8'h11, 1, 1'b0);
    // Category zero with a clear, then the magnitude extremes and special runs.
    queue_symbol(1'b1, 0, 8'h00, 0, 1'b1);
    queue_symbol(1'b0, 0, 8'h01, 0, 1'b0);
    queue_symbol(1'b0, 0, SYM_ZRL, 0, 1'b0);
    queue_symbol(1'b0, 0, 8'h30, 0, 1'b0);        // size zero with a run
    queue_symbol(1'b0, 0, 8'h0F, 32'h7FFF, 1'b0);
    queue_symbol(1'b0, 0, 8'h2F, 0, 1'b0);
    queue_symbol(1'b0, 0, 8'h05, 32'h7FE0, 1'b0); // surplus bits above the size
    queue_symbol(1'b0, 0, SYM_EOB, 0, 1'b0);
    queue_symbol(1'b0, 0, SYM_EOB, 0, 1'b0);      // end of block with none open
    // High nibble of a DC symbol is ignored; then an overlong run past index 63.
    queue_symbol(1'b1, 1, 8'hFB, 32'h7FFF, 1'b0);
    repeat (3) queue_symbol(1'b0, 1, SYM_ZRL, 0, 1'b0);
    queue_symbol(1'b0, 1, 8'hF5, 32'h1F, 1'b0);
    queue_symbol(1'b0, 1, 8'h12, 3, 1'b0);        // block already closed
    // Most negative category-15 value twice: the second DC abandons the block
    // and the predictor wraps.
    queue_symbol(1'b1, 2, 8'h0F, 0, 1'b0);
    queue_symbol(1'b1, 2, 8'h0F, 0, 1'b0);
    queue_symbol(1'b0, 2, SYM_EOB, 0, 1'b0);
    // Component without a predictor, and a clear arriving on an AC symbol.
    queue_symbol(1'b1, 3, 8'h05, 3, 1'b0);
    queue_symbol(1'b0, 3, 8'h01, 1, 1'b1);
    queue_symbol(1'b0, 3, SYM_EOB, 0, 1'b0);
    // Clear together with a DC symbol, then a block filled exactly to 63.
    queue_symbol(1'b1, 1, 8'h01, 1, 1'b1);
    repeat (3) queue_symbol(1'b0, 1, SYM_ZRL, 0, 1'b0);
    queue_symbol(1'b0, 1, 8'hD1, 0, 1'b0);
    queue_symbol(1'b0, 1, 8'h01, 1, 1'b0);

    // Random part: mostly well-formed blocks with random content, the rest
    // abandoned blocks and arbitrary symbols.
    while (symbol_queue.size() < TOTAL_SYMBOLS) begin
      r = $urandom_range(0, 99);
      if (r < 82) begin
        comp = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2);
        sym = $urandom_range(0, 11);
        if ($urandom_range(0, 7) == 0) sym = sym | ($urandom_range(1, 15) << 4);
        queue_symbol(1'b1, comp, sym, $urandom_range(0, 32767), $urandom_range(0, 19) == 0);
        pos = 1;
        while (pos < BLOCK_COEFFS) begin
          r = $urandom_range(0, 99);
          if (r < 4) break;
          if (r < 16 || (pos > 40 && r < 45)) begin
            queue_symbol(1'b0, comp, SYM_EOB, $urandom_range(0, 32767), 1'b0);
            pos = BLOCK_COEFFS;
          end else begin
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
            size = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 10);
            queue_symbol(1'b0, comp, (run << 4) | size, $urandom_range(0, 32767),
                         $urandom_range(0, 49) == 0);
            pos = ((run << 4) | size) == SYM_EOB ? BLOCK_COEFFS : pos + run + 1;
          end
        end
      end else begin
        queue_symbol(1'($urandom_range(0, 1)), $urandom_range(0, 3), $urandom_range(0, 255),
                     $urandom_range(0, 32767), $urandom_range(0, 9) == 0);
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Sample away from the active edge so the queues are settled.
    do @(negedge clk);
    while (symbol_queue.size() != 0 || in_valid || expected_coefs.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_coefs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
